FILE: hdl/bnms_pkg.sv
// ============================================================================
// bnms_pkg: shared types and constants for the box NMS unit
// Controller states, command and status bundles, and register indexes.
// ============================================================================
package bnms_pkg;

    localparam int SCORE_W   = 16;
    localparam int THR_W     = 16;
    localparam int IDX_OUT_W = 6;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MODE      = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

    // overlap_mode codes
    localparam logic MODE_UNION = 1'b0;
    localparam logic MODE_MIN   = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FIND_START,
        ST_FIND_RUN,
        ST_FIND_DRAIN,
        ST_PICK,
        ST_BEST_LATCH,
        ST_SCAN_START,
        ST_SCAN_RUN,
        ST_SCAN_DRAIN,
        ST_EMIT_START,
        ST_EMIT_RUN
    } state_t;

    typedef struct packed {
        logic load;        // take the input word
        logic rd_start;    // rewind the scan pointer
        logic rd_step;     // read entry at the pointer, advance
        logic prune;       // reads in flight feed the overlap pipe
        logic rd_best;     // read the best entry, mark it kept
        logic latch_best;  // capture the best box corners
        logic emit;        // push one result word, advance
        logic finish;      // close the set
    } cmd_t;

    typedef struct packed {
        logic rd_last;     // pointer sits on the last stored box
        logic pipe_busy;   // reads or overlap checks still in flight
        logic found;       // a surviving box was found by the last search
        logic out_free;    // result register can take a word
    } sts_t;

endpackage

FILE: hdl/box_nonmax_suppression_unit.sv
// ============================================================================
// box_nonmax_suppression_unit: greedy IoU non-maximum suppression
// Loads a set of scored boxes, suppresses overlaps, reports a keep bit per box.
// ============================================================================
// Boxes stream in one word per cycle and are stored in load order, up to
// MAX_BOXES per set; extra boxes are dropped and the set is flagged as
// overflowed. The word with s_tlast closes the set and starts suppression:
// each round scans the n stored scores to pick the best surviving box,
// reads it, then streams all n boxes through the overlap pipe; a set
// needs up to n rounds, one per kept box, and the box memory has a single
// read port. Then n result words go out, one per cycle when m_tready stays
// high, the last one with m_tlast. A new set is taken while the final result
// word still waits. Overlap is the inclusive intersection over the union or
// the smaller area, compared without division.
// Write the overlap limit (index 0) and overlap_mode (index 1) only while idle.
module box_nonmax_suppression_unit #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic aclk,
    input  logic aresetn,

    // left, top, right, bottom, confidence (lowest bit first), zero padded
    input  logic [((4*COORD_BITS+16+7)/8)*8-1:0] s_tdata,
    input  logic                                 s_tvalid,
    input  logic                                 s_tlast,   // final_box
    output logic                                 s_tready,

    // box_index[5:0], keep[6], zero pad[7]
    output logic [7:0] m_tdata,
    output logic       m_tuser,   // overflow
    output logic       m_tlast,   // end_of_set
    output logic       m_tvalid,
    input  logic       m_tready,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    bnms_pkg::cmd_t cmd;
    bnms_pkg::sts_t sts;

    // sequencer: hold input until the set is done
    bnms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage, search and overlap arithmetic
    bnms_dp #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_word   (s_tdata[4*COORD_BITS+15:0]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // never push a result over one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result pushed while output register full");

    // only a found box may be marked kept
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_best |-> sts.found)
        else $error("best box read without a survivor");

    // closing a set stops input until suppression is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken after set closed");

endmodule

FILE: hdl/bnms_ctrl.sv
// ============================================================================
// bnms_ctrl: sequencer for the box NMS unit
// Steps load, best-box search, pruning scan and result output.
// ============================================================================
module bnms_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tlast,
    output logic            s_tready,
    input  bnms_pkg::sts_t  sts,
    output bnms_pkg::cmd_t  cmd
);

    bnms_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bnms_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bnms_pkg::ST_LOAD: begin
                if (s_tvalid && s_tlast) state_next = bnms_pkg::ST_FIND_START;
            end
            bnms_pkg::ST_FIND_START: state_next = bnms_pkg::ST_FIND_RUN;
            bnms_pkg::ST_FIND_RUN: begin
                if (sts.rd_last) state_next = bnms_pkg::ST_FIND_DRAIN;
            end
            bnms_pkg::ST_FIND_DRAIN: state_next = bnms_pkg::ST_PICK;
            bnms_pkg::ST_PICK: begin
                state_next = sts.found ? bnms_pkg::ST_BEST_LATCH : bnms_pkg::ST_EMIT_START;
            end
            bnms_pkg::ST_BEST_LATCH: state_next = bnms_pkg::ST_SCAN_START;
            bnms_pkg::ST_SCAN_START: state_next = bnms_pkg::ST_SCAN_RUN;
            bnms_pkg::ST_SCAN_RUN: begin
                if (sts.rd_last) state_next = bnms_pkg::ST_SCAN_DRAIN;
            end
            bnms_pkg::ST_SCAN_DRAIN: begin
                if (!sts.pipe_busy) state_next = bnms_pkg::ST_FIND_START;
            end
            bnms_pkg::ST_EMIT_START: state_next = bnms_pkg::ST_EMIT_RUN;
            bnms_pkg::ST_EMIT_RUN: begin
                if (sts.out_free && sts.rd_last) state_next = bnms_pkg::ST_LOAD;
            end
            default: state_next = bnms_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            bnms_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            bnms_pkg::ST_FIND_START: cmd.rd_start = 1'b1;
            bnms_pkg::ST_FIND_RUN:   cmd.rd_step  = 1'b1;
            bnms_pkg::ST_FIND_DRAIN: ;
            bnms_pkg::ST_PICK:       cmd.rd_best  = sts.found;
            bnms_pkg::ST_BEST_LATCH: cmd.latch_best = 1'b1;
            bnms_pkg::ST_SCAN_START: cmd.rd_start = 1'b1;
            bnms_pkg::ST_SCAN_RUN: begin
                cmd.rd_step = 1'b1;
                cmd.prune   = 1'b1;
            end
            bnms_pkg::ST_SCAN_DRAIN: ;
            bnms_pkg::ST_EMIT_START: cmd.rd_start = 1'b1;
            bnms_pkg::ST_EMIT_RUN: begin
                cmd.emit   = sts.out_free;
                cmd.finish = sts.out_free && sts.rd_last;
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/bnms_dp.sv
// ============================================================================
// bnms_dp: datapath for the box NMS unit
// Box memory, alive and kept flags, best-score search and overlap pipe.
// ============================================================================
module bnms_dp #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bnms_pkg::cmd_t                cmd,
    output bnms_pkg::sts_t                sts,
    input  logic [4*COORD_BITS+15:0]      in_word,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_wdata,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [7:0]                    m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam int C       = COORD_BITS;
    localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W   = $clog2(MAX_BOXES + 1);
    localparam int ENTRY_W = 4*C + bnms_pkg::SCORE_W;
    localparam int INT_W   = 2*C + 2;
    localparam int DEN_W   = 2*C + 4;
    localparam int P_W     = bnms_pkg::THR_W + DEN_W;

    // ---- configuration
    logic [bnms_pkg::THR_W-1:0] thr_reg;
    logic                       mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= bnms_pkg::THR_RESET;
            mode_reg <= bnms_pkg::MODE_UNION;
        end else if (cfg_wr_en) begin
            if (cfg_index == bnms_pkg::CFG_THRESHOLD) thr_reg <= cfg_wdata;
            else                                      mode_reg <= cfg_wdata[0];
        end
    end

    // ---- set bookkeeping
    logic [CNT_W-1:0]     count_reg;
    logic                 ovf_reg;
    logic [MAX_BOXES-1:0] alive_reg, kept_reg;
    logic [IDX_W-1:0]     ptr_reg;
    logic                 room;

    assign room = (count_reg < CNT_W'(MAX_BOXES));

    // ---- best-score search
    logic                         found_reg;
    logic [IDX_W-1:0]             best_idx_reg;
    logic [bnms_pkg::SCORE_W-1:0] best_score_reg;
    logic [bnms_pkg::SCORE_W-1:0] rd_score;

    // ---- box memory
    logic [ENTRY_W-1:0] mem [MAX_BOXES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;

    assign rd_addr = cmd.rd_best ? best_idx_reg : ptr_reg;
    assign rd_en   = cmd.rd_best || cmd.rd_step;

    always_ff @(posedge aclk) begin
        if (cmd.load && room) mem[count_reg[IDX_W-1:0]] <= in_word;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    logic             rd_vld_reg, rd_prune_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    assign rd_score = rd_data_reg[ENTRY_W-1 -: bnms_pkg::SCORE_W];

    // ---- overlap pipe
    logic [C-1:0] rx1, ry1, rx2, ry2;
    logic [C-1:0] bx1_reg, by1_reg, bx2_reg, by2_reg;
    logic signed [INT_W-1:0] barea_reg;
    logic signed [C:0] bdx, bdy, rdx, rdy;
    logic [C-1:0] ix1, ix2, iy1, iy2;
    logic signed [C+1:0] wd, hd;

    assign rx1 = rd_data_reg[C-1:0];
    assign ry1 = rd_data_reg[2*C-1:C];
    assign rx2 = rd_data_reg[3*C-1:2*C];
    assign ry2 = rd_data_reg[4*C-1:3*C];

    assign bdx = $signed({1'b0, bx2_reg}) - $signed({1'b0, bx1_reg});
    assign bdy = $signed({1'b0, by2_reg}) - $signed({1'b0, by1_reg});
    assign rdx = $signed({1'b0, rx2}) - $signed({1'b0, rx1});
    assign rdy = $signed({1'b0, ry2}) - $signed({1'b0, ry1});

    assign ix1 = (rx1 > bx1_reg) ? rx1 : bx1_reg;
    assign ix2 = (rx2 < bx2_reg) ? rx2 : bx2_reg;
    assign iy1 = (ry1 > by1_reg) ? ry1 : by1_reg;
    assign iy2 = (ry2 < by2_reg) ? ry2 : by2_reg;
    assign wd  = $signed({2'b00, ix2}) - $signed({2'b00, ix1}) + $signed((C+2)'(1));
    assign hd  = $signed({2'b00, iy2}) - $signed({2'b00, iy1}) + $signed((C+2)'(1));

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]        i1_reg, i2_reg, i3_reg, i4_reg;
    logic [C:0]              w1_reg, h1_reg;
    logic signed [C:0]       dx1_reg, dy1_reg;
    logic [INT_W-1:0]        inter2_reg, inter3_reg;
    logic signed [INT_W-1:0] area2_reg;
    logic signed [DEN_W-1:0] denom3_reg, den_union, den_min;
    logic [P_W-1:0]          prod4_reg, inter_sh;
    logic [INT_W-1:0]        inter4_reg;
    logic                    neg4_reg, suppress;

    assign den_union = DEN_W'(area2_reg) + DEN_W'(barea_reg)
                     - $signed({{(DEN_W-INT_W){1'b0}}, inter2_reg});
    assign den_min   = (area2_reg < barea_reg) ? DEN_W'(area2_reg) : DEN_W'(barea_reg);
    assign inter_sh  = P_W'({inter4_reg, 16'h0000});
    assign suppress  = !neg4_reg && (inter_sh > prod4_reg);

    always_ff @(posedge aclk) begin
        barea_reg <= INT_W'(bdx) * INT_W'(bdy);
        w1_reg    <= wd[C+1] ? '0 : wd[C:0];
        h1_reg    <= hd[C+1] ? '0 : hd[C:0];
        dx1_reg   <= rdx;
        dy1_reg   <= rdy;
        i1_reg    <= rd_idx_reg;
        inter2_reg <= INT_W'(w1_reg) * INT_W'(h1_reg);
        area2_reg  <= INT_W'(dx1_reg) * INT_W'(dy1_reg);
        i2_reg     <= i1_reg;
        inter3_reg <= inter2_reg;
        denom3_reg <= (mode_reg == bnms_pkg::MODE_MIN) ? den_min : den_union;
        i3_reg     <= i2_reg;
        neg4_reg   <= denom3_reg[DEN_W-1];
        prod4_reg  <= P_W'(thr_reg) * P_W'(denom3_reg[DEN_W-2:0]);
        inter4_reg <= inter3_reg;
        i4_reg     <= i3_reg;
        if (cmd.latch_best) begin
            bx1_reg <= rx1;
            by1_reg <= ry1;
            bx2_reg <= rx2;
            by2_reg <= ry2;
        end
    end

    // ---- result register
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_keep_reg, out_ovf_reg, out_last_reg, out_vld_reg;

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_idx_reg  <= ptr_reg;
            out_keep_reg <= kept_reg[ptr_reg];
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= sts.rd_last;
        end
    end

    // ---- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            alive_reg    <= '0;
            kept_reg     <= '0;
            ptr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_prune_reg <= 1'b0;
            rd_idx_reg   <= '0;
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
            best_score_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.rd_step;
            rd_prune_reg <= cmd.prune;
            rd_idx_reg   <= ptr_reg;
            v1_reg <= rd_vld_reg && rd_prune_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            if (cmd.load) begin
                if (room) begin
                    alive_reg[count_reg[IDX_W-1:0]] <= 1'b1;
                    count_reg <= count_reg + CNT_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end

            if (cmd.rd_start) begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end else if (cmd.rd_step || cmd.emit) begin
                ptr_reg <= ptr_reg + IDX_W'(1);
            end

            // ascending scan with strict compare: ties stay with the lower index
            if (rd_vld_reg && !rd_prune_reg && alive_reg[rd_idx_reg]
                && (!found_reg || rd_score > best_score_reg)) begin
                found_reg      <= 1'b1;
                best_idx_reg   <= rd_idx_reg;
                best_score_reg <= rd_score;
            end

            if (cmd.rd_best) begin
                kept_reg[best_idx_reg]  <= 1'b1;
                alive_reg[best_idx_reg] <= 1'b0;
            end

            if (v4_reg && suppress) alive_reg[i4_reg] <= 1'b0;

            if (cmd.emit)       out_vld_reg <= 1'b1;
            else if (m_tready)  out_vld_reg <= 1'b0;

            if (cmd.finish) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                alive_reg <= '0;
                kept_reg  <= '0;
            end
        end
    end

    assign sts.rd_last   = ({1'b0, ptr_reg} == CNT_W'(count_reg - CNT_W'(1)));
    assign sts.pipe_busy = rd_vld_reg || v1_reg || v2_reg || v3_reg || v4_reg;
    assign sts.found     = found_reg;
    assign sts.out_free  = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_keep_reg, bnms_pkg::IDX_OUT_W'(out_idx_reg)};
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

endmodule
